// ----- hdl/pss_pkg.sv -----
// Shared types and codes for the positional sequence store.
package pss_pkg;

	localparam int MODE_W = 2;
	localparam int POS_W  = 5;
	localparam int VAL_W  = 32;
	localparam int SIZE_W = 5;
	localparam int STAT_W = 2;

	localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_op_t;

endpackage

// ----- hdl/pss_cell.sv -----
// One storage cell of the sequence row: holds one element word.
module pss_cell #(
	parameter int ELEM_WIDTH = 32
) (
	input  logic                  clk,
	input  pss_pkg::cell_op_t     op,
	input  logic [ELEM_WIDTH-1:0] left_data,
	input  logic [ELEM_WIDTH-1:0] right_data,
	input  logic [ELEM_WIDTH-1:0] load_data,
	output logic [ELEM_WIDTH-1:0] data
);
	import pss_pkg::*;

	logic [ELEM_WIDTH-1:0] data_q;

	// A cell takes the new word, or the word of a neighbor when the row shifts.
	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD:       data_q <= load_data;
			CELL_FROM_LEFT:  data_q <= left_data;
			CELL_FROM_RIGHT: data_q <= right_data;
			default:         data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// ----- hdl/positional_sequence_store.sv -----
// Top level of the positional sequence store: control, cell row and result register.
//
// The block keeps an ordered sequence of up to DEPTH element words in a row of
// identical cells, addressed by one-based positions. Each input beat carries a mode
// (read, insert or remove) in tuser and a position plus a value in tdata. An insert
// opens a gap as every later cell takes its left neighbor's word and the cell at the
// position loads the new word; a remove closes it as that cell and every later one take
// their right neighbor's word, and returns the removed word. Bad positions, inserts
// into a full store and reads or removes on an empty store are flagged in the status
// code and leave the store unchanged. The block accepts one beat per clock cycle unless
// the output stalls: the whole row shifts at once and the read is one position-indexed
// select, so the rate is set by that select and the count compare. Every result appears
// in an output register in the cycle after its beat is accepted, and a new beat can
// enter while the previous result is being taken. After reset the store is empty; no
// clearing pass is needed because a cell at or beyond the current size is never read.
module positional_sequence_store #(
	parameter int DEPTH      = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: position [4:0], value [36:5], zero fill [39:37].
	input  logic [39:0] s_tdata,
	// s_tuser: mode [1:0].
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: element_out [31:0], size [36:32], is_empty [37], zero fill [39:38].
	output logic [39:0] m_tdata,
	// m_tuser: status [1:0].
	output logic [1:0]  m_tuser
);
	import pss_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	logic [MODE_W-1:0] mode;
	logic [POS_W-1:0]  position;
	logic [VAL_W-1:0]  value;

	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  out_elem_q;
	logic [SIZE_W-1:0] out_size_q;
	logic              out_empty_q;
	logic [STAT_W-1:0] out_status_q;

	logic [CMP_W-1:0]  pos_x;
	logic [CMP_W-1:0]  pos_m1;
	logic [CMP_W-1:0]  cnt_x;
	logic              pos_ok_rd;
	logic              pos_ok_ins;
	logic              full;
	logic              op_ok;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  count_next;
	logic [IDX_W-1:0]  rd_idx;
	logic [ELEM_WIDTH-1:0] rd_data;
	logic [ELEM_WIDTH-1:0] load_word;
	logic [VAL_W-1:0]  elem_res;
	logic              s_fire;

	cell_op_t              cell_op   [DEPTH];
	logic [ELEM_WIDTH-1:0] cell_data [DEPTH];

	assign mode     = s_tuser;
	assign position = s_tdata[POS_W-1:0];
	assign value    = s_tdata[POS_W+VAL_W-1:POS_W];

	assign s_tready = !out_valid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	// Position checks against the current fill level.
	assign pos_x      = CMP_W'(position);
	assign pos_m1     = pos_x - CMP_W'(1);
	assign cnt_x      = CMP_W'(count_q);
	assign pos_ok_rd  = (position != '0) && (pos_x <= cnt_x);
	assign pos_ok_ins = (position != '0) && (pos_x <= cnt_x + CMP_W'(1));
	assign full       = (count_q == CNT_W'(DEPTH));

	always_comb begin
		case (mode)
			MODE_READ, MODE_REMOVE: begin
				status = pos_ok_rd ? ST_DONE : ST_RANGE;
			end
			MODE_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					status = pos_ok_ins ? ST_DONE : ST_RANGE;
				end
			end
			default: status = ST_RANGE;
		endcase
	end

	assign op_ok = s_fire && (status == ST_DONE);

	always_comb begin
		count_next = count_q;
		if (op_ok && (mode == MODE_INSERT)) begin
			count_next = count_q + CNT_W'(1);
		end else if (op_ok && (mode == MODE_REMOVE)) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// Cell controls: for an insert the cell at the position loads the new word and later
	// cells shift back; for a remove that cell and later ones shift forward. Cells past the
	// fill level may shift too; their contents are never read.
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			cell_op[k] = CELL_HOLD;
			if (op_ok && (mode == MODE_INSERT)) begin
				if (CMP_W'(k) == pos_m1) begin
					cell_op[k] = CELL_LOAD;
				end else if (CMP_W'(k) > pos_m1) begin
					cell_op[k] = CELL_FROM_LEFT;
				end
			end else if (op_ok && (mode == MODE_REMOVE)) begin
				if (CMP_W'(k) >= pos_m1) begin
					cell_op[k] = CELL_FROM_RIGHT;
				end
			end
		end
	end

	assign load_word = ELEM_WIDTH'(value);

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic [ELEM_WIDTH-1:0] left_w;
			logic [ELEM_WIDTH-1:0] right_w;
			if (g == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = cell_data[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign right_w = '0;
			end else begin : g_mid_r
				assign right_w = cell_data[g+1];
			end
			pss_cell #(
				.ELEM_WIDTH(ELEM_WIDTH)
			) u_cell (
				.clk       (clk),
				.op        (cell_op[g]),
				.left_data (left_w),
				.right_data(right_w),
				.load_data (load_word),
				.data      (cell_data[g])
			);
		end
	endgenerate

	// The read select only matters when the position is in range, which keeps the
	// index inside the row.
	assign rd_idx   = IDX_W'(pos_m1);
	assign rd_data  = cell_data[rd_idx];
	assign elem_res = ((status == ST_DONE) && (mode != MODE_INSERT)) ?
		VAL_W'(rd_data) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (s_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The result payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			out_elem_q   <= elem_res;
			out_size_q   <= SIZE_W'(count_next);
			out_empty_q  <= (count_next == '0);
			out_status_q <= status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_empty_q, out_size_q, out_elem_q};
	assign m_tuser  = out_status_q;

	// The fill level never passes the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill level exceeds the cell count");

	// A rejected operation leaves the fill level as it was.
	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (status != ST_DONE)) |=> $stable(count_q))
		else $error("rejected operation changed the fill level");

	// A completed insert grows the sequence by one.
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (status == ST_DONE) && (mode == MODE_INSERT))
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the sequence");

	// An error result never carries an element word.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != ST_DONE)) |-> (out_elem_q == '0))
		else $error("error result carries an element");

	// A reported empty store always comes with a zero fill level.
	a_empty_size: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_empty_q) |-> (out_size_q == '0))
		else $error("empty flag disagrees with the size");

endmodule

// ----- test/tb_positional_sequence_store.sv -----
// Self-checking testbench for the positional sequence store: directed table plus random traffic.
module tb_positional_sequence_store;
	timeunit 1ns;
	timeprecision 1ps;

	import pss_pkg::*;

	localparam int DEPTH      = 16;
	localparam int ELEM_WIDTH = 32;
	localparam int RANDOM_OPS = 1800;
	localparam int HOLD_LEN   = 40;

	// The fourth mode code has no meaning and must come back as a range error.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// One result beat, split into its fields.
	typedef struct packed {
		logic [VAL_W-1:0]  element;
		logic [SIZE_W-1:0] size;
		logic              is_empty;
		logic [STAT_W-1:0] status;
	} seq_result_t;

	// One row of the directed table. A row repeats its operation reps times, bumping the
	// value by one each time. Rows with typed set carry their result; the rest use the
	// predictor.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0]  pos;
		logic [VAL_W-1:0]  value;
		logic [4:0]        reps;
		logic              typed;
		seq_result_t       want;
	} op_row_t;

	typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_t;

	localparam seq_result_t NO_CHECK = '0;
	localparam int DIR_ROWS = 26;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	// Predicted contents of the store and its current length.
	logic [ELEM_WIDTH-1:0] seq_mem [DEPTH];
	int                    seq_len;

	seq_result_t pending_results [$];
	int          n_errors;
	bit          calm;
	bit          stall_req;

	op_row_t dir_table [DIR_ROWS] = '{
		// Empty store: nothing can be read or removed, insert only at position one.
		'{MODE_READ,   5'd1,  32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd0, 1'b1, ST_RANGE}},
		'{MODE_REMOVE, 5'd1,  32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd0, 1'b1, ST_RANGE}},
		'{MODE_INSERT, 5'd0,  32'h1234_5678, 5'd1,  1'b1, '{32'h0, 5'd0, 1'b1, ST_RANGE}},
		'{MODE_INSERT, 5'd2,  32'h1234_5678, 5'd1,  1'b1, '{32'h0, 5'd0, 1'b1, ST_RANGE}},
		'{MODE_UNUSED, 5'd1,  32'hFFFF_FFFF, 5'd1,  1'b1, '{32'h0, 5'd0, 1'b1, ST_RANGE}},
		// Value extremes go in at the front.
		'{MODE_INSERT, 5'd1,  32'hFFFF_FFFF, 5'd1,  1'b1, '{32'h0, 5'd1, 1'b0, ST_DONE}},
		'{MODE_INSERT, 5'd1,  32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd2, 1'b0, ST_DONE}},
		'{MODE_READ,   5'd1,  32'h0000_0000, 5'd1,  1'b0, NO_CHECK},
		'{MODE_READ,   5'd2,  32'h0000_0000, 5'd1,  1'b0, NO_CHECK},
		'{MODE_READ,   5'd3,  32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd2, 1'b0, ST_RANGE}},
		'{MODE_READ,   5'd0,  32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd2, 1'b0, ST_RANGE}},
		'{MODE_REMOVE, 5'd31, 32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd2, 1'b0, ST_RANGE}},
		// Append at size plus one, then fill up through the middle.
		'{MODE_INSERT, 5'd3,  32'h5A5A_C33C, 5'd1,  1'b1, '{32'h0, 5'd3, 1'b0, ST_DONE}},
		'{MODE_INSERT, 5'd2,  32'h1000_0000, 5'd13, 1'b0, NO_CHECK},
		// Full store: the full check wins over any position check.
		'{MODE_INSERT, 5'd1,  32'hAAAA_AAAA, 5'd1,  1'b1, '{32'h0, 5'd16, 1'b0, ST_FULL}},
		'{MODE_INSERT, 5'd17, 32'h5555_5555, 5'd1,  1'b1, '{32'h0, 5'd16, 1'b0, ST_FULL}},
		'{MODE_INSERT, 5'd0,  32'h5555_5555, 5'd1,  1'b1, '{32'h0, 5'd16, 1'b0, ST_FULL}},
		'{MODE_UNUSED, 5'd5,  32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd16, 1'b0, ST_RANGE}},
		'{MODE_READ,   5'd16, 32'h0000_0000, 5'd1,  1'b0, NO_CHECK},
		'{MODE_READ,   5'd17, 32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd16, 1'b0, ST_RANGE}},
		// Remove from both ends and from the middle.
		'{MODE_REMOVE, 5'd16, 32'h0000_0000, 5'd1,  1'b0, NO_CHECK},
		'{MODE_REMOVE, 5'd1,  32'h0000_0000, 5'd1,  1'b0, NO_CHECK},
		'{MODE_INSERT, 5'd8,  32'h8000_0001, 5'd1,  1'b0, NO_CHECK},
		'{MODE_REMOVE, 5'd8,  32'h0000_0000, 5'd1,  1'b0, NO_CHECK},
		// Drain the whole store from the front and look at the empty store again.
		'{MODE_REMOVE, 5'd1,  32'h0000_0000, 5'd14, 1'b0, NO_CHECK},
		'{MODE_READ,   5'd1,  32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd0, 1'b1, ST_RANGE}}
	};

	positional_sequence_store #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one operation to the predicted store and returns the result it should give.
	function automatic seq_result_t seq_apply(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
			logic [VAL_W-1:0] val);
		seq_result_t r;
		int k;
		r.element = '0;
		r.status  = ST_DONE;
		case (mode)
			MODE_READ: begin
				if (pos == 0 || pos > seq_len)
					r.status = ST_RANGE;
				else
					r.element = seq_mem[pos - 1];
			end
			MODE_INSERT: begin
				if (seq_len >= DEPTH) begin
					r.status = ST_FULL;
				end else if (pos == 0 || pos > seq_len + 1) begin
					r.status = ST_RANGE;
				end else begin
					// Later elements move back one place to open the gap.
					for (k = seq_len; k >= pos; k--)
						seq_mem[k] = seq_mem[k - 1];
					seq_mem[pos - 1] = val;
					seq_len++;
				end
			end
			MODE_REMOVE: begin
				if (pos == 0 || pos > seq_len) begin
					r.status = ST_RANGE;
				end else begin
					r.element = seq_mem[pos - 1];
					for (k = pos; k < seq_len; k++)
						seq_mem[k - 1] = seq_mem[k];
					seq_len--;
				end
			end
			default: r.status = ST_RANGE;
		endcase
		r.size     = SIZE_W'(seq_len);
		r.is_empty = (seq_len == 0);
		return r;
	endfunction

	// Mostly back-to-back, often a short gap, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Offers one beat, waits for the handshake and records what it should produce.
	task automatic send_op(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val, input bit typed, input seq_result_t typed_res);
		int gap;
		seq_result_t res;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {3'b000, val, pos};
		do @(posedge clk); while (!s_tready);
		res = seq_apply(mode, pos, val);
		pending_results.push_back(typed ? typed_res : res);
	endtask

	// Sender goes quiet until every outstanding result has been taken.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_result();
		seq_result_t got;
		seq_result_t want;
		got.element  = m_tdata[31:0];
		got.size     = m_tdata[36:32];
		got.is_empty = m_tdata[37];
		got.status   = m_tuser;
		if (pending_results.size() == 0) begin
			$error("result beat with no pending operation: tdata %h tuser %h", m_tdata, m_tuser);
			n_errors++;
		end else begin
			want = pending_results.pop_front();
			if (got.element !== want.element) begin
				$error("element_out: expected %h, got %h", want.element, got.element);
				n_errors++;
			end
			if (got.size !== want.size) begin
				$error("size: expected %0d, got %0d", want.size, got.size);
				n_errors++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %b, got %b", want.is_empty, got.is_empty);
				n_errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				n_errors++;
			end
		end
	endtask

	// Result side: checks every accepted beat and drives tready with random idling. A stall
	// request from the sender side makes it hold tready low in one unbroken stretch.
	initial begin
		int idle_left;
		int hold_left;
		idle_left = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				check_result();
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_req) begin
				stall_req = 1'b0;
				hold_left = HOLD_LEN - 1;
				m_tready <= 1'b0;
			end else if (idle_left != 0) begin
				idle_left--;
				m_tready <= 1'b0;
			end else if (calm || $urandom_range(0, 99) < 70) begin
				m_tready <= 1'b1;
			end else begin
				idle_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
					: $urandom_range(0, 2);
				m_tready <= 1'b0;
			end
		end
	end

	// Stimulus: reset, the directed table, then random traffic.
	initial begin
		int i;
		int j;
		int n;
		int r;
		int ins_pct;
		int rd_pct;
		op_mix_t mix;
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;

		n_errors  = 0;
		seq_len   = 0;
		calm      = 1'b0;
		stall_req = 1'b0;
		mix       = MIX_EVEN;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= MODE_READ;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++)
			for (j = 0; j < dir_table[i].reps; j++)
				send_op(dir_table[i].mode, dir_table[i].pos, dir_table[i].value + VAL_W'(j),
					dir_table[i].typed, dir_table[i].want);
		drain();

		for (n = 0; n < RANDOM_OPS; n++) begin
			if (n % 100 == 0)
				mix = op_mix_t'($urandom_range(0, 2));
			if (n % 150 == 0)
				calm = ($urandom_range(0, 3) == 0);
			// Long receiver hold-offs with the sender offering every cycle fill the block up.
			if (n == 300 || n == 1100) begin
				calm      = 1'b1;
				stall_req = 1'b1;
			end
			if (n == 700 || n == 1500)
				drain();

			r = $urandom_range(0, 99);
			if (r < 8) begin
				// Malformed beats: unused mode, position zero, positions past the end.
				case ($urandom_range(0, 3))
					0: begin
						mode = MODE_UNUSED;
						pos  = POS_W'($urandom_range(0, 31));
					end
					1: begin
						mode = MODE_W'($urandom_range(0, 2));
						pos  = '0;
					end
					2: begin
						mode = ($urandom_range(0, 1) != 0) ? MODE_READ : MODE_REMOVE;
						pos  = POS_W'($urandom_range(seq_len + 1, 31));
					end
					default: begin
						mode = MODE_INSERT;
						pos  = POS_W'($urandom_range(seq_len + 2, 31));
					end
				endcase
			end else begin
				case (mix)
					MIX_GROW: begin
						ins_pct = 55;
						rd_pct  = 25;
					end
					MIX_SHRINK: begin
						ins_pct = 20;
						rd_pct  = 25;
					end
					default: begin
						ins_pct = 35;
						rd_pct  = 30;
					end
				endcase
				r = $urandom_range(0, 99);
				if (r < ins_pct)
					mode = MODE_INSERT;
				else if (r < ins_pct + rd_pct)
					mode = MODE_READ;
				else
					mode = MODE_REMOVE;
				if (mode == MODE_INSERT)
					pos = POS_W'($urandom_range(1, seq_len + 1));
				else if (seq_len == 0)
					pos = 5'd1;
				else
					pos = POS_W'($urandom_range(1, seq_len));
			end

			case ($urandom_range(0, 9))
				0: val = '0;
				1: val = '1;
				default: val = $urandom();
			endcase
			send_op(mode, pos, val, 1'b0, NO_CHECK);
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// Wait on so that any stray result beat is caught.
		repeat (8) @(posedge clk);
		if (n_errors == 0)
			$display("tb_positional_sequence_store passed");
		else
			$display("tb_positional_sequence_store failed");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("tb_positional_sequence_store failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/pss_pkg.sv
hdl/pss_cell.sv
hdl/positional_sequence_store.sv
test/tb_positional_sequence_store.sv
